// File: design/i2f_pkg.sv
// Shared types, constants and CRC helper for the image-data to frame-data chunk rewriter.
`timescale 1ns / 1ps

package i2f_pkg;

  // CRC-32 constants (reflected form)
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Replacement letters for the first two bytes of the chunk type
  localparam logic [7:0] TYPE_F = 8'h66;
  localparam logic [7:0] TYPE_D = 8'h64;

  // Work passed from the front part to the back part
  typedef enum logic [1:0] {
    CMD_LEN     = 2'd0,  // four bytes of the new length
    CMD_TYPESEQ = 2'd1,  // last type byte followed by four sequence bytes
    CMD_DATA    = 2'd2,  // one byte that passes through and enters the CRC
    CMD_CRC     = 2'd3   // one byte of the new CRC
  } i2f_kind_t;

  typedef struct packed {
    i2f_kind_t   kind;
    logic [7:0]  byte_val;  // data or type byte; CRC byte position in the low bits
    logic [31:0] payload;   // length plus four, or sequence number
  } i2f_cmd_t;

  // One byte through the reflected CRC-32, a bit at a time
  function automatic logic [31:0] crc_feed_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: design/i2f_front.sv
// Front part: accepts input words, tracks chunk fields and issues commands.
`timescale 1ns / 1ps

module i2f_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_byte,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  output logic              cmd_push,
  output i2f_pkg::i2f_cmd_t cmd
);
  import i2f_pkg::*;

  typedef enum logic [3:0] {
    PH_LEN  = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_DATA = 4'b0100,
    PH_CRC  = 4'b1000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] seq_r;
  logic [31:0] len_shift;
  logic [7:0]  type_byte;

  // Sequence number register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else if (cfg_wr_en) begin
      seq_r <= cfg_wr_data;
    end
  end

  assign len_shift = {len_r[23:0], in_byte};

  // The first two type letters are replaced
  always_comb begin
    case (idx_r)
      2'd0:    type_byte = TYPE_F;
      2'd1:    type_byte = TYPE_D;
      default: type_byte = in_byte;
    endcase
  end

  // Field tracking and command generation
  always_comb begin
    phase_nxt    = phase_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    cmd_push     = 1'b0;
    cmd.kind     = CMD_DATA;
    cmd.byte_val = in_byte;
    cmd.payload  = seq_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_LEN: begin
          len_nxt = len_shift;
          if (idx_r == 2'd3) begin
            cmd_push    = 1'b1;
            cmd.kind    = CMD_LEN;
            cmd.payload = len_shift + 32'd4;
            rem_nxt     = len_shift;
            idx_nxt     = 2'd0;
            phase_nxt   = PH_TYPE;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        PH_TYPE: begin
          cmd_push     = 1'b1;
          cmd.byte_val = type_byte;
          if (idx_r == 2'd3) begin
            cmd.kind  = CMD_TYPESEQ;
            idx_nxt   = 2'd0;
            phase_nxt = (rem_r != 32'd0) ? PH_DATA : PH_CRC;
          end else begin
            cmd.kind = CMD_DATA;
            idx_nxt  = idx_r + 2'd1;
          end
        end
        PH_DATA: begin
          cmd_push = 1'b1;
          cmd.kind = CMD_DATA;
          rem_nxt  = rem_r - 32'd1;
          if (rem_r == 32'd1) begin
            idx_nxt   = 2'd0;
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          cmd_push     = 1'b1;
          cmd.kind     = CMD_CRC;
          cmd.byte_val = {6'd0, idx_r};
          if (idx_r == 2'd3) begin
            idx_nxt   = 2'd0;
            len_nxt   = '0;
            phase_nxt = PH_LEN;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        default: begin
          // Corrupt phase: drop the word and wait for a length
          idx_nxt   = 2'd0;
          phase_nxt = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEN;
      idx_r   <= 2'd0;
      len_r   <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// File: design/i2f_fifo.sv
// Short command queue between the front and back parts.
`timescale 1ns / 1ps

module i2f_fifo #(
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2f_pkg::i2f_cmd_t push_cmd,
  input  logic              pop,
  output i2f_pkg::i2f_cmd_t head_cmd,
  output logic              head_valid,
  output logic              full,
  output logic [CNT_W-1:0]  level
);
  import i2f_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  i2f_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: design/i2f_back.sv
// Back part: expands commands into output words and keeps the running CRC.
`timescale 1ns / 1ps

module i2f_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  i2f_pkg::i2f_cmd_t head_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_chunk_last
);
  import i2f_pkg::*;

  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  byte_r;
  logic        run_last_r, chunk_last_r;
  logic [7:0]  sel_byte;
  logic        last_of_cmd;
  logic        chunk_end;
  logic        advance;
  logic [31:0] crc_final;

  assign crc_final = crc_r ^ CRC_INIT;
  assign advance   = head_valid && (!valid_r || out_ready);
  assign chunk_end = (head_cmd.kind == CMD_CRC) && (head_cmd.byte_val[1:0] == 2'd3);

  // Byte selection for the current step of the command
  always_comb begin
    sel_byte    = head_cmd.byte_val;
    last_of_cmd = 1'b1;
    unique case (head_cmd.kind)
      CMD_LEN: begin
        last_of_cmd = (cnt_r == 3'd3);
        case (cnt_r[1:0])
          2'd0:    sel_byte = head_cmd.payload[31:24];
          2'd1:    sel_byte = head_cmd.payload[23:16];
          2'd2:    sel_byte = head_cmd.payload[15:8];
          default: sel_byte = head_cmd.payload[7:0];
        endcase
      end
      CMD_TYPESEQ: begin
        last_of_cmd = (cnt_r == 3'd4);
        case (cnt_r)
          3'd0:    sel_byte = head_cmd.byte_val;
          3'd1:    sel_byte = head_cmd.payload[31:24];
          3'd2:    sel_byte = head_cmd.payload[23:16];
          3'd3:    sel_byte = head_cmd.payload[15:8];
          default: sel_byte = head_cmd.payload[7:0];
        endcase
      end
      CMD_DATA: begin
        sel_byte = head_cmd.byte_val;
      end
      CMD_CRC: begin
        case (head_cmd.byte_val[1:0])
          2'd0:    sel_byte = crc_final[31:24];
          2'd1:    sel_byte = crc_final[23:16];
          2'd2:    sel_byte = crc_final[15:8];
          default: sel_byte = crc_final[7:0];
        endcase
      end
      default: sel_byte = head_cmd.byte_val;
    endcase
  end

  // CRC register: restarts with each length, absorbs type, sequence and data
  always_comb begin
    crc_nxt = crc_r;
    if (advance) begin
      case (head_cmd.kind) inside
        CMD_LEN:                crc_nxt = CRC_INIT;
        CMD_TYPESEQ, CMD_DATA:  crc_nxt = crc_feed_byte(crc_r, sel_byte);
        default:                crc_nxt = chunk_end ? CRC_INIT : crc_r;
      endcase
    end
  end

  // Step counter and output register
  always_comb begin
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    if (advance) begin
      cnt_nxt   = last_of_cmd ? 3'd0 : cnt_r + 3'd1;
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  assign pop = advance && last_of_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 3'd0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r       <= sel_byte;
      run_last_r   <= last_of_cmd;
      chunk_last_r <= chunk_end;
    end
  end

  assign out_valid      = valid_r;
  assign out_byte       = byte_r;
  assign out_run_last   = run_last_r;
  assign out_chunk_last = chunk_last_r;

endmodule

// File: design/idat_to_fdat_chunk_rewriter_core.sv
// Path: an accepted input word is written into the command queue and then into the output
// register before its first output word is shown; length words one to three give none.
// Throughput: the back part sends one output word per cycle unless the queue is empty or the
// output stalls; the fourth length word gives four output words and the fourth type word five,
// other words one; the FIFO_DEPTH-entry command queue lets input words arrive until it is full.
// Reset: synchronous active-low rst_n clears the phase, queue, CRC and sequence number.
`timescale 1ns / 1ps

module idat_to_fdat_chunk_rewriter_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] out_byte
  output logic        out_tuser,    // [0] run_last
  output logic        out_tlast,    // chunk_last
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data   // sequence_number
);
  import i2f_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic             in_fire;
  logic             cmd_push;
  i2f_cmd_t         cmd;
  i2f_cmd_t         head_cmd;
  logic             head_valid;
  logic             fifo_full;
  logic             cmd_pop;
  logic [CNT_W-1:0] fifo_level;

  assign in_tready = !fifo_full;
  assign in_fire   = in_tvalid && in_tready;

  i2f_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_push    (cmd_push),
    .cmd         (cmd)
  );

  i2f_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .pop        (cmd_pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid),
    .full       (fifo_full),
    .level      (fifo_level)
  );

  i2f_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .pop            (cmd_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .out_run_last   (out_tuser),
    .out_chunk_last (out_tlast)
  );

  // The final CRC word always closes the run of its input word
  a_chunk_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser)
    else $error("chunk end without run end");

  // Queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= CNT_W'(FIFO_DEPTH))
    else $error("command queue overfilled");

  // Nothing is presented in the cycle after a reset edge
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // A command is only retired when the back part can send a word
  a_pop_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (head_valid && (!out_tvalid || out_tready)))
    else $error("command retired while output stalled");

endmodule
